// ----- sv/fpk_pkg.sv -----
// Shared types, format codes and constants for the float-to-PCM frame packer.
// Used by every module of the block; has no dependencies of its own.
package fpk_pkg;

    // Output format register codes.
    localparam logic [3:0] FMT_U8_MONO    = 4'd0;
    localparam logic [3:0] FMT_U8_STEREO  = 4'd1;
    localparam logic [3:0] FMT_S16_MONO   = 4'd2;
    localparam logic [3:0] FMT_S16_STEREO = 4'd3;
    localparam logic [3:0] FMT_S24_MONO   = 4'd4;
    localparam logic [3:0] FMT_S24_STEREO = 4'd5;
    localparam logic [3:0] FMT_S32_MONO   = 4'd6;
    localparam logic [3:0] FMT_S32_STEREO = 4'd7;
    localparam logic [3:0] FMT_F32_MONO   = 4'd8;
    localparam logic [3:0] FMT_F32_STEREO = 4'd9;
    localparam logic [3:0] FMT_RESET      = FMT_S16_STEREO;
    localparam logic [3:0] FMT_LAST       = FMT_F32_STEREO;

    // Sample encoding, the format code without its stereo bit.
    localparam logic [2:0] KIND_U8  = 3'd0;
    localparam logic [2:0] KIND_S16 = 3'd1;
    localparam logic [2:0] KIND_S24 = 3'd2;
    localparam logic [2:0] KIND_S32 = 3'd3;
    localparam logic [2:0] KIND_F32 = 3'd4;

    // Single-precision bit patterns.
    localparam logic [31:0] F32_POS_ONE = 32'h3F80_0000;
    localparam logic [31:0] F32_NEG_ONE = 32'hBF80_0000;
    localparam logic [31:0] F32_QNAN    = 32'h7FC0_0000;
    localparam logic [30:0] F32_INF_MAG = 31'h7F80_0000;

    // One stereo frame with the format it was accepted under.
    typedef struct packed {
        logic [3:0]  fmt;
        logic [31:0] right;
        logic [31:0] left;
    } fpk_frame_t;

    // Frame plus the single-precision channel average.
    typedef struct packed {
        logic [3:0]  fmt;
        logic [31:0] right;
        logic [31:0] left;
        logic [31:0] mono;
    } fpk_mix_t;

    // One quantized channel. word holds the integer or float encoding;
    // u8_mag is |x*127.5| in fixed point with 26 fraction bits and a
    // sticky bit below them.
    typedef struct packed {
        logic [31:0] word;
        logic        u8_neg;
        logic [33:0] u8_mag;
    } fpk_chan_t;

    typedef struct packed {
        logic [3:0] fmt;
        fpk_chan_t  chan_b;
        fpk_chan_t  chan_a;
    } fpk_quant_t;

    typedef struct packed {
        logic [3:0]  byte_count;
        logic [63:0] frame_bytes;
    } fpk_result_t;

    function automatic logic [2:0] fmt_kind(input logic [3:0] fmt);
        return fmt[3:1];
    endfunction

endpackage

// ----- sv/float_to_pcm_frame_packer_core.sv -----
// Float-to-PCM frame packer: top level with the format register and the
// handshake. Depends on fpk_pkg, fpk_mono_add, fpk_quant and fpk_pack.
//
// Usage:
//   Each s_ transaction carries one stereo frame of two single-precision
//   samples. Each m_ transaction returns the frame converted to the format
//   in the output format register, packed little-endian with the left
//   channel first, plus its byte count. Mono formats use (l+r)*0.5.
//   The format register is written with cfg_wr_en while the block is idle;
//   a frame takes the format in force when it is accepted. Frames accepted
//   under a format code above 9 produce no result.
// Pipeline and throughput:
//   A result passes through four adder stages, three quantizer stages
//   (multiply, round, truncate) and two packing stages. One frame is
//   accepted every cycle while s_tready is high.
// Reset:
//   aresetn (synchronous, active low) empties the pipeline and sets the
//   format to 16-bit stereo.
// Stall:
//   While m_tready is low the result is held and earlier stages keep
//   filling; s_tready drops only once every stage holds a frame.
module float_to_pcm_frame_packer_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [3:0]  cfg_wr_data,  // output_format
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,      // [31:0] left_sample, [63:32] right_sample
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata       // [63:0] frame_bytes, [67:64] byte_count
);
    import fpk_pkg::*;

    logic        [3:0] fmt_reg;
    fpk_frame_t        frame;
    logic              fmt_ok;
    logic              mix_valid, mix_ready, q_valid, q_ready;
    fpk_mix_t          mix_data;
    fpk_quant_t        q_data;
    fpk_result_t       res;

    // Output format register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fmt_reg <= FMT_RESET;
        end else if (cfg_wr_en) begin
            fmt_reg <= cfg_wr_data;
        end
    end

    // Frames under an undefined format are accepted and dropped.
    assign fmt_ok      = (fmt_reg <= FMT_LAST);
    assign frame.fmt   = fmt_reg;
    assign frame.left  = s_tdata[31:0];
    assign frame.right = s_tdata[63:32];

    fpk_mono_add u_mono_add (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid && fmt_ok),
        .in_ready  (s_tready),
        .in_data   (frame),
        .out_valid (mix_valid),
        .out_ready (mix_ready),
        .out_data  (mix_data)
    );

    fpk_quant u_quant (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (mix_valid),
        .in_ready  (mix_ready),
        .in_data   (mix_data),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_data  (q_data)
    );

    fpk_pack u_pack (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (q_valid),
        .in_ready  (q_ready),
        .in_data   (q_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (res)
    );

    assign m_tdata = {4'd0, res.byte_count, res.frame_bytes};

`ifndef ASSERT_OFF
    // After reset the empty pipeline takes a frame at once.
    a_ready_after_reset: assert property (@(posedge aclk)
        !aresetn |=> s_tready)
        else $error("s_tready low after reset");

    // Only the six legal byte counts appear.
    a_count_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[67:64] == 4'd1 || m_tdata[67:64] == 4'd2 ||
                      m_tdata[67:64] == 4'd3 || m_tdata[67:64] == 4'd4 ||
                      m_tdata[67:64] == 4'd6 || m_tdata[67:64] == 4'd8))
        else $error("illegal byte count");

    // Bytes beyond a four-byte frame are zero.
    a_pad_four: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[67:64] == 4'd4) |-> (m_tdata[63:32] == 32'd0))
        else $error("nonzero bytes beyond a four-byte frame");

    // Bytes beyond a one-byte frame are zero.
    a_pad_one: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[67:64] == 4'd1) |-> (m_tdata[63:8] == 56'd0))
        else $error("nonzero bytes beyond a one-byte frame");
`endif

endmodule

// ----- sv/fpk_mono_add.sv -----
// Four-stage single-precision adder computing (left+right)*0.5 with
// round-to-nearest-even, denormals and specials. Depends on fpk_pkg.
module fpk_mono_add (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  fpk_pkg::fpk_frame_t in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output fpk_pkg::fpk_mix_t  out_data
);
    import fpk_pkg::*;

    typedef struct packed {
        logic        sa;
        logic [7:0]  ea;
        logic [26:0] ma;
        logic [26:0] mb;
        logic        sub;
        logic        nan;
        logic        inf;
        logic        infs;
    } align_t;

    typedef struct packed {
        logic        sa;
        logic [7:0]  ea;
        logic [27:0] sum;
        logic        sub;
        logic        nan;
        logic        inf;
        logic        infs;
    } sum_t;

    typedef struct packed {
        logic        sg;
        logic [8:0]  e;
        logic [26:0] n;
        logic        nan;
        logic        inf;
        logic        infs;
    } norm_t;

    logic       v1_reg, v2_reg, v3_reg, v4_reg;
    logic       v1_next, v2_next, v3_next, v4_next;
    logic       rdy1, rdy2, rdy3, rdy4;
    fpk_frame_t f1_reg, f2_reg, f3_reg, f4_reg;
    align_t     a1_reg, a1_next;
    sum_t       s2_reg, s2_next;
    norm_t      n3_reg, n3_next;
    logic [31:0] mono4_reg, mono4_next;

    // Each stage loads when it is empty or its successor moves on.
    assign rdy4     = !v4_reg || out_ready;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    assign v1_next = rdy1 ? in_valid : v1_reg;
    assign v2_next = rdy2 ? v1_reg   : v2_reg;
    assign v3_next = rdy3 ? v2_reg   : v3_reg;
    assign v4_next = rdy4 ? v3_reg   : v4_reg;

    // Stage 1: unpack, order by magnitude, align the smaller operand.
    always_comb begin
        logic [31:0] l, r, a, b;
        logic        l_nan, r_nan, l_inf, r_inf, swap;
        logic [7:0]  eb, d;
        logic [23:0] mb;
        logic [4:0]  dd;
        logic [52:0] wide;
        l     = in_data.left;
        r     = in_data.right;
        l_nan = (&l[30:23]) && (|l[22:0]);
        r_nan = (&r[30:23]) && (|r[22:0]);
        l_inf = (&l[30:23]) && !(|l[22:0]);
        r_inf = (&r[30:23]) && !(|r[22:0]);
        swap  = r[30:0] > l[30:0];
        a     = swap ? r : l;
        b     = swap ? l : r;
        a1_next.sa   = a[31];
        a1_next.ea   = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
        eb           = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
        a1_next.ma   = {|a[30:23], a[22:0], 3'b000};
        mb           = {|b[30:23], b[22:0]};
        d            = a1_next.ea - eb;
        dd           = (d > 8'd28) ? 5'd28 : d[4:0];
        wide         = {mb, 29'd0} >> dd;
        a1_next.mb   = {wide[52:27], |wide[26:0]};
        a1_next.sub  = a[31] ^ b[31];
        a1_next.nan  = l_nan || r_nan || (l_inf && r_inf && (l[31] ^ r[31]));
        a1_next.inf  = l_inf || r_inf;
        a1_next.infs = l_inf ? l[31] : r[31];
    end

    // Stage 2: magnitude add or subtract.
    always_comb begin
        s2_next.sa   = a1_reg.sa;
        s2_next.ea   = a1_reg.ea;
        s2_next.sub  = a1_reg.sub;
        s2_next.nan  = a1_reg.nan;
        s2_next.inf  = a1_reg.inf;
        s2_next.infs = a1_reg.infs;
        s2_next.sum  = a1_reg.sub ? ({1'b0, a1_reg.ma} - {1'b0, a1_reg.mb})
                                  : ({1'b0, a1_reg.ma} + {1'b0, a1_reg.mb});
    end

    // Stage 3: normalize, stopping at the denormal exponent.
    always_comb begin
        logic [4:0] lz;
        logic [7:0] lim, sl;
        n3_next.nan  = s2_reg.nan;
        n3_next.inf  = s2_reg.inf;
        n3_next.infs = s2_reg.infs;
        lz = 5'd27;
        for (int i = 0; i < 27; i++) begin
            if (s2_reg.sum[i]) begin
                lz = 5'(26 - i);
            end
        end
        lim = s2_reg.ea - 8'd1;
        sl  = ({3'b000, lz} > lim) ? lim : {3'b000, lz};
        if (s2_reg.sum[27]) begin
            n3_next.n = {s2_reg.sum[27:2], |s2_reg.sum[1:0]};
            n3_next.e = {1'b0, s2_reg.ea} + 9'd1;
        end else begin
            n3_next.n = s2_reg.sum[26:0] << sl[4:0];
            n3_next.e = {1'b0, s2_reg.ea} - {1'b0, sl};
            if (!n3_next.n[26]) begin
                n3_next.e = 9'd0;
            end
        end
        // An exact cancellation gives +0; two zeros of one sign keep it.
        if (s2_reg.sum == 28'd0) begin
            n3_next.sg = s2_reg.sub ? 1'b0 : s2_reg.sa;
        end else begin
            n3_next.sg = s2_reg.sa;
        end
    end

    // Stage 4: round to nearest even, apply specials, then halve.
    always_comb begin
        logic        up, hup;
        logic [30:0] mag;
        logic [31:0] sum;
        logic [23:0] half;
        up = n3_reg.n[2] && ((|n3_reg.n[1:0]) || n3_reg.n[3]);
        if (n3_reg.e >= 9'd255) begin
            mag = F32_INF_MAG;
        end else begin
            mag = {n3_reg.e[7:0], n3_reg.n[25:3]} + {30'd0, up};
        end
        if (n3_reg.nan) begin
            sum = F32_QNAN;
        end else if (n3_reg.inf) begin
            sum = {n3_reg.infs, F32_INF_MAG};
        end else begin
            sum = {n3_reg.sg, mag};
        end
        // Halving is exact unless the result leaves the normal range.
        hup  = sum[0] && sum[1];
        half = {1'b0, sum[23:1]} + {23'd0, hup};
        if (sum[30:23] == 8'hFF) begin
            mono4_next = sum;
        end else if (sum[30:23] >= 8'd2) begin
            mono4_next = {sum[31], sum[30:23] - 8'd1, sum[22:0]};
        end else begin
            mono4_next = {sum[31], 7'd0, half};
        end
    end

    // Valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            v4_reg <= v4_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (rdy1) begin
            f1_reg <= in_data;
            a1_reg <= a1_next;
        end
        if (rdy2) begin
            f2_reg <= f1_reg;
            s2_reg <= s2_next;
        end
        if (rdy3) begin
            f3_reg <= f2_reg;
            n3_reg <= n3_next;
        end
        if (rdy4) begin
            f4_reg    <= f3_reg;
            mono4_reg <= mono4_next;
        end
    end

    assign out_valid      = v4_reg;
    assign out_data.fmt   = f4_reg.fmt;
    assign out_data.right = f4_reg.right;
    assign out_data.left  = f4_reg.left;
    assign out_data.mono  = mono4_reg;

endmodule

// ----- sv/fpk_quant.sv -----
// Three-stage quantizer: clamps both channels, scales them by the format's
// constant, rounds the product as float or double and truncates.
// Depends on fpk_pkg.
module fpk_quant (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  fpk_pkg::fpk_mix_t   in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output fpk_pkg::fpk_quant_t out_data
);
    import fpk_pkg::*;

    typedef struct packed {
        logic [55:0] prod;
        logic        neg;
        logic        zero;
        logic [7:0]  e;
        logic [7:0]  off;
        logic [31:0] bits;
    } prod_t;

    typedef struct packed {
        logic [53:0] rm;
        logic [7:0]  q;
        logic        neg;
        logic        zero;
        logic [31:0] bits;
    } rnd_t;

    logic       v1_reg, v2_reg, v3_reg;
    logic       rdy1, rdy2, rdy3;
    logic [3:0] fmt1_reg, fmt2_reg, fmt3_reg;
    prod_t      pa_reg, pb_reg, pa_next, pb_next;
    rnd_t       ra_reg, rb_reg, ra_next, rb_next;
    fpk_chan_t  ca_reg, cb_reg, ca_next, cb_next;

    assign rdy3     = !v3_reg || out_ready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    // Saturate to [-1,1]; NaN becomes +0.
    function automatic logic [31:0] clamp_unit(input logic [31:0] v);
        if ((&v[30:23]) && (|v[22:0])) begin
            return 32'd0;
        end else if (v[30:0] > F32_POS_ONE[30:0]) begin
            return v[31] ? F32_NEG_ONE : F32_POS_ONE;
        end
        return v;
    endfunction

    // Scale constant left-aligned to 32 bits, and the exponent offset that
    // places the binary point of the rounded product.
    function automatic logic [39:0] scale_sel(input logic [2:0] kind, input logic neg);
        case (kind)
            KIND_U8:  return {8'd143, 32'hFF00_0000};
            KIND_S16: return {8'd135, 32'hFFFE_0000};
            KIND_S24: return neg ? {8'd126, 32'h8000_0000} : {8'd127, 32'hFFFF_FE00};
            KIND_S32: return neg ? {8'd147, 32'h8000_0000} : {8'd148, 32'hFFFF_FFFE};
            default:  return {8'd143, 32'hFF00_0000};
        endcase
    endfunction

    function automatic prod_t mul_stage(input logic [31:0] src, input logic [2:0] kind);
        prod_t       p;
        logic [31:0] x;
        logic [39:0] sc;
        x      = clamp_unit(src);
        sc     = scale_sel(kind, x[31]);
        p.bits = x;
        p.neg  = x[31];
        p.e    = x[30:23];
        p.zero = (x[30:23] == 8'd0);
        p.off  = sc[39:32];
        p.prod = {1'b1, x[22:0]} * sc[31:0];
        return p;
    endfunction

    // Normalize by one place and round to 24 or 53 significant bits.
    function automatic rnd_t rnd_stage(input prod_t p, input logic dbl);
        rnd_t        r;
        logic        ns, up;
        logic [55:0] pn;
        logic [8:0]  q9;
        ns = !p.prod[55];
        pn = ns ? {p.prod[54:0], 1'b0} : p.prod;
        if (dbl) begin
            up   = pn[2] && ((|pn[1:0]) || pn[3]);
            r.rm = {1'b0, pn[55:3]} + {53'd0, up};
        end else begin
            up   = pn[31] && ((|pn[30:0]) || pn[32]);
            r.rm = {30'd0, pn[55:32]} + {53'd0, up};
        end
        q9     = {1'b0, p.off} + {8'd0, ns} - {1'b0, p.e};
        r.q    = q9[7:0];
        r.neg  = p.neg;
        r.zero = p.zero;
        r.bits = p.bits;
        return r;
    endfunction

    // Truncate toward zero; for 8-bit output keep the fixed-point magnitude.
    function automatic fpk_chan_t trunc_stage(input rnd_t r, input logic [2:0] kind);
        fpk_chan_t   c;
        logic [53:0] mag;
        logic [31:0] iv;
        logic [7:0]  sa;
        logic [5:0]  sa6;
        logic [97:0] tmp;
        mag = (r.q >= 8'd54) ? 54'd0 : (r.rm >> r.q);
        iv  = r.neg ? (32'd0 - mag[31:0]) : mag[31:0];
        sa  = r.q - 8'd16;
        sa6 = (sa > 8'd63) ? 6'd63 : sa[5:0];
        tmp = {r.rm[24:0], 10'd0, 63'd0} >> sa6;
        c.u8_neg = r.neg;
        c.u8_mag = r.zero ? 34'd0 : {tmp[95:63], |tmp[62:0]};
        if (kind == KIND_F32) begin
            c.word = r.bits;
        end else if (r.zero) begin
            c.word = 32'd0;
        end else begin
            c.word = iv;
        end
        return c;
    endfunction

    // Stage 1: channel select, clamp and multiply.
    always_comb begin
        pa_next = mul_stage(in_data.fmt[0] ? in_data.left : in_data.mono,
                            fmt_kind(in_data.fmt));
        pb_next = mul_stage(in_data.right, fmt_kind(in_data.fmt));
    end

    // Stage 2: product rounding, double precision for 32-bit integers.
    always_comb begin
        ra_next = rnd_stage(pa_reg, fmt_kind(fmt1_reg) == KIND_S32);
        rb_next = rnd_stage(pb_reg, fmt_kind(fmt1_reg) == KIND_S32);
    end

    // Stage 3: truncation.
    always_comb begin
        ca_next = trunc_stage(ra_reg, fmt_kind(fmt2_reg));
        cb_next = trunc_stage(rb_reg, fmt_kind(fmt2_reg));
    end

    // Valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (rdy1) begin
                v1_reg <= in_valid;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
            if (rdy3) begin
                v3_reg <= v2_reg;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (rdy1) begin
            fmt1_reg <= in_data.fmt;
            pa_reg   <= pa_next;
            pb_reg   <= pb_next;
        end
        if (rdy2) begin
            fmt2_reg <= fmt1_reg;
            ra_reg   <= ra_next;
            rb_reg   <= rb_next;
        end
        if (rdy3) begin
            fmt3_reg <= fmt2_reg;
            ca_reg   <= ca_next;
            cb_reg   <= cb_next;
        end
    end

    assign out_valid       = v3_reg;
    assign out_data.fmt    = fmt3_reg;
    assign out_data.chan_a = ca_reg;
    assign out_data.chan_b = cb_reg;

endmodule

// ----- sv/fpk_pack.sv -----
// Two-stage packer: finishes the 8-bit offset conversion (add 128, float
// rounding, truncation, bounding) and packs the frame little-endian.
// Depends on fpk_pkg.
module fpk_pack (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  fpk_pkg::fpk_quant_t  in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output fpk_pkg::fpk_result_t out_data
);
    import fpk_pkg::*;

    typedef struct packed {
        logic [34:0] d;
        logic [5:0]  lp;
        logic [31:0] word;
    } off_t;

    logic        v1_reg, v2_reg;
    logic        rdy1, rdy2;
    logic [3:0]  fmt1_reg;
    off_t        oa_reg, ob_reg, oa_next, ob_next;
    fpk_result_t res_reg, res_next;

    assign rdy2     = !v2_reg || out_ready;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    // 128 +/- m in fixed point (26 fraction bits, sticky lsb) and the
    // position of its leading one; the sum lies in [0.5, 256).
    function automatic off_t offset_stage(input fpk_chan_t c);
        off_t        o;
        logic [34:0] base;
        base = {8'd128, 27'd0};
        o.d  = c.u8_neg ? (base - {1'b0, c.u8_mag}) : (base + {1'b0, c.u8_mag});
        o.lp = 6'd26;
        for (int j = 26; j < 35; j++) begin
            if (o.d[j]) begin
                o.lp = 6'(j);
            end
        end
        o.word = c.word;
        return o;
    endfunction

    // Round to 24 significant bits, truncate and bound to 0..255.
    function automatic logic [7:0] u8_stage(input off_t o);
        logic [5:0]  lsb;
        logic [34:0] lowmask, half, rem, one;
        logic        up;
        logic [35:0] r;
        lsb     = o.lp - 6'd23;
        one     = 35'd1 << lsb;
        lowmask = one - 35'd1;
        half    = 35'd1 << (lsb - 6'd1);
        rem     = o.d & lowmask;
        up      = (rem > half) || ((rem == half) && o.d[lsb]);
        r       = {1'b0, o.d & ~lowmask} + (up ? {1'b0, one} : 36'd0);
        return (r[35:27] >= 9'd255) ? 8'hFF : r[34:27];
    endfunction

    always_comb begin
        oa_next = offset_stage(in_data.chan_a);
        ob_next = offset_stage(in_data.chan_b);
    end

    // Frame assembly; bytes beyond the count stay zero.
    always_comb begin
        logic        st;
        logic [31:0] a, b;
        st = fmt1_reg[0];
        a  = oa_reg.word;
        b  = st ? ob_reg.word : 32'd0;
        case (fmt_kind(fmt1_reg))
            KIND_U8: begin
                res_next.frame_bytes = {48'd0, st ? u8_stage(ob_reg) : 8'd0, u8_stage(oa_reg)};
                res_next.byte_count  = st ? 4'd2 : 4'd1;
            end
            KIND_S16: begin
                res_next.frame_bytes = {32'd0, b[15:0], a[15:0]};
                res_next.byte_count  = st ? 4'd4 : 4'd2;
            end
            KIND_S24: begin
                res_next.frame_bytes = {16'd0, b[23:0], a[23:0]};
                res_next.byte_count  = st ? 4'd6 : 4'd3;
            end
            default: begin
                res_next.frame_bytes = {b, a};
                res_next.byte_count  = st ? 4'd8 : 4'd4;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (rdy1) begin
                v1_reg <= in_valid;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            fmt1_reg <= in_data.fmt;
            oa_reg   <= oa_next;
            ob_reg   <= ob_next;
        end
        if (rdy2) begin
            res_reg <= res_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_data  = res_reg;

endmodule
